// ===== rtl/bsfr_pkg.sv =====
package bsfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PL_AW       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREAMBLE_BYTE   = 4'd0,
    CFG_FLAG_BYTE       = 4'd1,
    CFG_PREAMBLE_NEEDED = 4'd2,
    CFG_MAX_PAYLOAD_LEN = 4'd3,
    CFG_GROUP_ADDRESS   = 4'd4,
    CFG_OWN_ADDR        = 4'd5,
    CFG_CRC_POLY        = 4'd6,
    CFG_CRC_INIT        = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PREAMBLE   = 3'd1,
    EV_FLAG       = 3'd2,
    EV_BAD_LEN    = 3'd3,
    EV_BAD_CHAR   = 3'd4,
    EV_FRAME_OK   = 3'd5,
    EV_CRC_FAIL   = 3'd6,
    EV_ADDR_DROP  = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_FLAG     = 3'd1,
    PH_ADDRESS  = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CRC      = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]       preamble_byte;
    logic [7:0]       flag_byte;
    logic [3:0]       preamble_needed;
    logic [LEN_W-1:0] max_payload_len;
    logic [7:0]       group_address;
    logic [7:0]       own_addr;
    logic [7:0]       crc_poly;
    logic [7:0]       crc_init;
  } cfg_t;

  // result request from the byte state machine to the output stage
  typedef struct packed {
    logic             valid;
    logic             drain;
    event_e           ev;
    logic [7:0]       addr;
    logic [LEN_W-1:0] len;
  } rx_res_t;

endpackage

// ===== rtl/bsfr_ram.sv =====
module bsfr_ram
  import bsfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PL_AW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [PL_AW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [MAX_PAYLOAD];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bsfr_rx.sv =====
module bsfr_rx
  import bsfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             accept_i,
  input  logic             rx_bit_i,
  output rx_res_t          res_o,
  output logic             we_o,
  output logic [PL_AW-1:0] waddr_o,
  output logic [7:0]       wdata_o
);

  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic char_ok(logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) ||
           c == CH_SPACE || c == CH_DOT || c == CH_COMMA || c == CH_QUEST ||
           c == CH_EXCL || c == CH_DASH || c == CH_SLASH;
  endfunction

  logic [2:0]       bit_pos_q, bit_pos_d;
  logic [7:0]       asm_q, asm_d;
  phase_e           phase_q, phase_d;
  logic [3:0]       seen_q, seen_d;
  logic [7:0]       addr_q, addr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [7:0]       crc_q, crc_d;

  logic [7:0]       byte_w;
  logic             byte_done;
  logic [7:0]       crc_next;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] fill_inc;
  logic [3:0]       seen_inc;

  assign byte_w    = asm_q | ({7'd0, rx_bit_i} << bit_pos_q);
  assign byte_done = accept_i && (bit_pos_q == 3'd7);
  assign crc_next  = crc8_step(crc_q, byte_w, cfg_i.crc_poly);
  assign limit     = (cfg_i.max_payload_len < LEN_W'(MAX_PAYLOAD)) ?
                     cfg_i.max_payload_len : LEN_W'(MAX_PAYLOAD);
  assign fill_inc  = fill_q + LEN_W'(1);
  assign seen_inc  = (seen_q < cfg_i.preamble_needed) ? seen_q + 4'd1 : seen_q;

  assign waddr_o = fill_q[PL_AW-1:0];
  assign wdata_o = byte_w;

  always_comb begin
    bit_pos_d = bit_pos_q;
    asm_d     = asm_q;
    phase_d   = phase_q;
    seen_d    = seen_q;
    addr_d    = addr_q;
    len_d     = len_q;
    fill_d    = fill_q;
    crc_d     = crc_q;
    we_o      = 1'b0;
    res_o     = '0;

    if (accept_i) begin
      bit_pos_d = bit_pos_q + 3'd1;
      asm_d     = byte_done ? 8'd0 : byte_w;
    end

    if (byte_done) begin
      res_o.valid = 1'b1;
      res_o.ev    = EV_NONE;
      case (phase_q)
        PH_PREAMBLE: begin
          if (byte_w == cfg_i.preamble_byte) begin
            seen_d = seen_inc;
            if (seen_inc >= cfg_i.preamble_needed) begin
              phase_d  = PH_FLAG;
              res_o.ev = EV_PREAMBLE;
            end
          end else begin
            seen_d = 4'd0;
          end
        end
        PH_FLAG: begin
          if (byte_w == cfg_i.flag_byte) begin
            phase_d  = PH_ADDRESS;
            crc_d    = cfg_i.crc_init;
            res_o.ev = EV_FLAG;
          end else if (byte_w == cfg_i.preamble_byte) begin
            seen_d = cfg_i.preamble_needed;
          end else begin
            phase_d = PH_PREAMBLE;
          end
        end
        PH_ADDRESS: begin
          addr_d  = byte_w;
          crc_d   = crc_next;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          crc_d  = crc_next;
          fill_d = '0;
          if (byte_w > {1'b0, limit}) begin
            phase_d    = PH_PREAMBLE;
            res_o.ev   = EV_BAD_LEN;
            res_o.addr = addr_q;
          end else begin
            len_d   = byte_w[LEN_W-1:0];
            phase_d = (byte_w == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (!char_ok(byte_w) || fill_q >= LEN_W'(MAX_PAYLOAD)) begin
            phase_d    = PH_PREAMBLE;
            res_o.ev   = EV_BAD_CHAR;
            res_o.addr = addr_q;
            res_o.len  = len_q;
          end else begin
            we_o   = 1'b1;
            fill_d = fill_inc;
            crc_d  = crc_next;
            if (fill_inc >= len_q) begin
              phase_d = PH_CRC;
            end
          end
        end
        PH_CRC: begin
          phase_d    = PH_PREAMBLE;
          res_o.addr = addr_q;
          res_o.len  = len_q;
          if (addr_q != cfg_i.group_address && addr_q != cfg_i.own_addr) begin
            res_o.ev = EV_ADDR_DROP;
          end else if (byte_w != crc_q) begin
            res_o.ev = EV_CRC_FAIL;
          end else begin
            res_o.ev = EV_FRAME_OK;
            if (len_q > LEN_W'(MAX_PAYLOAD)) begin
              res_o.len = LEN_W'(MAX_PAYLOAD);
            end
            res_o.drain = (len_q != '0);
          end
        end
        default: begin
          phase_d = PH_PREAMBLE;
        end
      endcase

      // return to preamble search clears the frame state
      if (phase_d == PH_PREAMBLE && !(phase_q == PH_PREAMBLE)) begin
        seen_d = 4'd0;
        addr_d = 8'd0;
        len_d  = '0;
        fill_d = '0;
        crc_d  = cfg_i.crc_init;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q <= 3'd0;
      asm_q     <= 8'd0;
      phase_q   <= PH_PREAMBLE;
      seen_q    <= 4'd0;
      addr_q    <= 8'd0;
      len_q     <= '0;
      fill_q    <= '0;
      crc_q     <= 8'd0;
    end else begin
      bit_pos_q <= bit_pos_d;
      asm_q     <= asm_d;
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      addr_q    <= addr_d;
      len_q     <= len_d;
      fill_q    <= fill_d;
      crc_q     <= crc_d;
    end
  end

endmodule

// ===== rtl/bsfr_out.sv =====
module bsfr_out
  import bsfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rx_res_t          res_i,
  input  logic [7:0]       rdata_i,
  output logic             re_o,
  output logic [PL_AW-1:0] raddr_o,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output event_e           ev_o,
  output logic [7:0]       addr_o,
  output logic [LEN_W-1:0] len_o,
  output logic [7:0]       text_o,
  output logic             text_valid_o,
  output logic             last_o
);

  logic             out_valid_q, out_valid_d;
  event_e           ev_q, ev_d;
  logic [7:0]       addr_q, addr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       text_q, text_d;
  logic             tv_q, tv_d;
  logic             last_q, last_d;

  logic             drain_q, drain_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] dlen_q, dlen_d;
  logic [7:0]       daddr_q, daddr_d;
  logic             have_q, have_d;
  logic             rd_last_q, rd_last_d;

  logic out_free;
  logic issue;
  logic load_drain;

  assign out_free   = !out_valid_q || out_ready_i;
  assign issue      = drain_q && (idx_q < dlen_q) && (!have_q || out_free);
  assign load_drain = have_q && out_free;
  assign in_ready_o = !drain_q && out_free;
  assign re_o       = issue;
  assign raddr_o    = idx_q[PL_AW-1:0];

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    ev_d        = ev_q;
    addr_d      = addr_q;
    len_d       = len_q;
    text_d      = text_q;
    tv_d        = tv_q;
    last_d      = last_q;
    drain_d     = drain_q;
    idx_d       = idx_q;
    dlen_d      = dlen_q;
    daddr_d     = daddr_q;
    have_d      = have_q;
    rd_last_d   = rd_last_q;

    if (issue) begin
      idx_d     = idx_q + LEN_W'(1);
      rd_last_d = (idx_q == dlen_q - LEN_W'(1));
      have_d    = 1'b1;
    end else if (load_drain) begin
      have_d = 1'b0;
    end

    if (load_drain) begin
      out_valid_d = 1'b1;
      ev_d        = EV_FRAME_OK;
      addr_d      = daddr_q;
      len_d       = dlen_q;
      text_d      = rdata_i;
      tv_d        = 1'b1;
      last_d      = rd_last_q;
      if (rd_last_q) begin
        drain_d = 1'b0;
      end
    end else if (res_i.valid && res_i.drain) begin
      drain_d = 1'b1;
      idx_d   = '0;
      dlen_d  = res_i.len;
      daddr_d = res_i.addr;
      have_d  = 1'b0;
    end else if (res_i.valid) begin
      out_valid_d = 1'b1;
      ev_d        = res_i.ev;
      addr_d      = res_i.addr;
      len_d       = res_i.len;
      text_d      = 8'd0;
      tv_d        = 1'b0;
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drain_q     <= 1'b0;
      have_q      <= 1'b0;
      idx_q       <= '0;
      dlen_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      drain_q     <= drain_d;
      have_q      <= have_d;
      idx_q       <= idx_d;
      dlen_q      <= dlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q      <= ev_d;
    addr_q    <= addr_d;
    len_q     <= len_d;
    text_q    <= text_d;
    tv_q      <= tv_d;
    last_q    <= last_d;
    daddr_q   <= daddr_d;
    rd_last_q <= rd_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ev_o         = ev_q;
  assign addr_o       = addr_q;
  assign len_o        = len_q;
  assign text_o       = text_q;
  assign text_valid_o = tv_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/bit_serial_frame_receiver_crc8_unit.sv =====
// Bit-serial frame receiver with CRC8 check. Line bits enter one item per cycle, LSB of each
// byte first; every eighth bit completes a byte that yields one result with an event code
// (preamble, flag, bad length, bad char, frame ok, crc fail, address drop or none). Payload
// characters are written into a 64-entry payload memory as they arrive; when a frame passes
// the address and CRC checks its N characters are read back one per cycle while the output
// stage is free and sent as N results, the last one with tlast; a frame with no characters
// gives a single result without text. Input is held off while that run is read out and
// while the output register holds a result that is not taken. Otherwise one bit is taken
// every cycle. The payload memory needs no clearing after reset. Configuration registers
// are written through cfg_we_i with the index on cfg_idx_i; other indexes are ignored.
module bit_serial_frame_receiver_crc8_unit
  import bsfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [0] rx_bit
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // [7:0] frame_address, [14:8] frame_length,
                                              // [22:15] text_byte
  output logic [3:0]           m_axis_tuser,  // [2:0] event_res, [3] text_valid
  output logic                 m_axis_tlast
);

  cfg_t             cfg_q;
  rx_res_t          res;
  logic             accept;
  logic             we;
  logic [PL_AW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [PL_AW-1:0] raddr;
  logic [7:0]       rdata;
  event_e           ev;
  logic [7:0]       addr;
  logic [LEN_W-1:0] len;
  logic [7:0]       text;
  logic             text_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_byte   <= 8'h55;
      cfg_q.flag_byte       <= 8'h7E;
      cfg_q.preamble_needed <= 4'd2;
      cfg_q.max_payload_len <= LEN_W'(MAX_PAYLOAD);
      cfg_q.group_address   <= 8'hFF;
      cfg_q.own_addr        <= 8'h00;
      cfg_q.crc_poly        <= 8'h07;
      cfg_q.crc_init        <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREAMBLE_BYTE:   cfg_q.preamble_byte   <= cfg_data_i;
        CFG_FLAG_BYTE:       cfg_q.flag_byte       <= cfg_data_i;
        CFG_PREAMBLE_NEEDED: cfg_q.preamble_needed <= cfg_data_i[3:0];
        CFG_MAX_PAYLOAD_LEN: cfg_q.max_payload_len <= cfg_data_i[LEN_W-1:0];
        CFG_GROUP_ADDRESS:   cfg_q.group_address   <= cfg_data_i;
        CFG_OWN_ADDR:        cfg_q.own_addr        <= cfg_data_i;
        CFG_CRC_POLY:        cfg_q.crc_poly        <= cfg_data_i;
        CFG_CRC_INIT:        cfg_q.crc_init        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  bsfr_rx u_rx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .rx_bit_i (s_axis_tdata[0]),
    .res_o    (res),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata)
  );

  bsfr_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bsfr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .rdata_i      (rdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .in_ready_o   (s_axis_tready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .ev_o         (ev),
    .addr_o       (addr),
    .len_o        (len),
    .text_o       (text),
    .text_valid_o (text_valid),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, text, len, addr};
  assign m_axis_tuser = {text_valid, ev};

endmodule

// ===== test/bit_serial_frame_receiver_crc8_unit_tb.sv =====
`timescale 1ns / 100ps

module bit_serial_frame_receiver_crc8_unit_tb
  import bsfr_pkg::*;
;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FLT_NONE,
    FLT_CRC,
    FLT_ADDR,
    FLT_CHAR,
    FLT_LEN,
    FLT_FLAG
  } frame_fault_e;

  typedef struct packed {
    event_e           ev;
    logic [7:0]       addr;
    logic [LEN_W-1:0] len;
    logic [7:0]       txt;
    logic             tv;
    logic             last;
  } frame_res_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [7:0]           cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic [3:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  bit_serial_frame_receiver_crc8_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // line bits waiting to be sent and results waiting to be seen
  logic       line_bits[$];
  frame_res_t pending_res[$];
  int         n_pushed = 0;
  int         n_err    = 0;
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;
  string      text_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 .,?!-/";

  // receiver state as predicted
  cfg_t             cfg_m;
  logic [2:0]       rx_pos   = '0;
  logic [7:0]       rx_byte  = '0;
  phase_e           rx_phase = PH_PREAMBLE;
  logic [3:0]       pre_cnt  = '0;
  logic [7:0]       rx_addr  = '0;
  logic [LEN_W-1:0] rx_len   = '0;
  logic [LEN_W-1:0] rx_fill  = '0;
  logic [7:0]       rx_crc   = '0;
  logic [7:0]       rx_text[MAX_PAYLOAD];

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ cfg_m.crc_poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic bit char_ok(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == " " || c == "." ||
           c == "," || c == "?" || c == "!" || c == "-" || c == "/";
  endfunction

  function automatic int payload_limit();
    return (cfg_m.max_payload_len < MAX_PAYLOAD) ? int'(cfg_m.max_payload_len) : MAX_PAYLOAD;
  endfunction

  function automatic void add_result(input event_e ev, input logic [7:0] addr,
                                     input logic [LEN_W-1:0] len, input logic [7:0] txt,
                                     input logic tv, input logic last);
    frame_res_t r;
    r.ev   = ev;
    r.addr = addr;
    r.len  = len;
    r.txt  = txt;
    r.tv   = tv;
    r.last = last;
    pending_res.push_back(r);
  endfunction

  function automatic void rx_restart();
    rx_phase = PH_PREAMBLE;
    pre_cnt  = '0;
    rx_addr  = '0;
    rx_len   = '0;
    rx_fill  = '0;
    rx_crc   = cfg_m.crc_init;
  endfunction

  task automatic predict_bit(input logic bit_in);
    logic [7:0]       b;
    logic [7:0]       a;
    logic [7:0]       c;
    logic [LEN_W-1:0] n;
    if (bit_in) rx_byte[rx_pos] = 1'b1;
    rx_pos = rx_pos + 3'd1;
    if (rx_pos != 3'd0) return;
    b       = rx_byte;
    rx_byte = '0;
    a       = rx_addr;
    n       = rx_len;
    case (rx_phase)
      PH_PREAMBLE: begin
        if (b == cfg_m.preamble_byte) begin
          if (pre_cnt < cfg_m.preamble_needed) pre_cnt++;
          if (pre_cnt >= cfg_m.preamble_needed) begin
            rx_phase = PH_FLAG;
            add_result(EV_PREAMBLE, '0, '0, '0, 1'b0, 1'b1);
            return;
          end
        end else begin
          pre_cnt = '0;
        end
      end
      PH_FLAG: begin
        if (b == cfg_m.flag_byte) begin
          rx_phase = PH_ADDRESS;
          rx_crc   = cfg_m.crc_init;
          add_result(EV_FLAG, '0, '0, '0, 1'b0, 1'b1);
          return;
        end else if (b == cfg_m.preamble_byte) begin
          pre_cnt = cfg_m.preamble_needed;
        end else begin
          rx_restart();
        end
      end
      PH_ADDRESS: begin
        rx_addr  = b;
        rx_crc   = crc8_next(rx_crc, b);
        rx_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        rx_crc  = crc8_next(rx_crc, b);
        rx_fill = '0;
        if (int'(b) > payload_limit()) begin
          rx_restart();
          add_result(EV_BAD_LEN, a, '0, '0, 1'b0, 1'b1);
          return;
        end
        rx_len   = b[LEN_W-1:0];
        rx_phase = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (!char_ok(b) || rx_fill >= MAX_PAYLOAD) begin
          rx_restart();
          add_result(EV_BAD_CHAR, a, n, '0, 1'b0, 1'b1);
          return;
        end
        rx_text[rx_fill] = b;
        rx_fill++;
        rx_crc = crc8_next(rx_crc, b);
        if (rx_fill >= rx_len) rx_phase = PH_CRC;
      end
      PH_CRC: begin
        c = rx_crc;
        rx_restart();
        if (a != cfg_m.group_address && a != cfg_m.own_addr) begin
          add_result(EV_ADDR_DROP, a, n, '0, 1'b0, 1'b1);
        end else if (b != c) begin
          add_result(EV_CRC_FAIL, a, n, '0, 1'b0, 1'b1);
        end else if (n == '0) begin
          add_result(EV_FRAME_OK, a, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < int'(n); k++) begin
            add_result(EV_FRAME_OK, a, n, rx_text[k], 1'b1, k == int'(n) - 1);
          end
        end
        return;
      end
      default: rx_restart();
    endcase
    add_result(EV_NONE, '0, '0, '0, 1'b0, 1'b1);
  endtask

  task automatic push_bit(input logic v);
    line_bits.push_back(v);
    n_pushed++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    for (int i = 0; i < 8; i++) push_bit(b[i]);
  endtask

  // random bits, then padded back onto a byte boundary
  task automatic line_noise();
    repeat ($urandom_range(1, 24)) push_bit(1'($urandom_range(0, 1)));
    while (n_pushed % 8 != 0) push_bit(1'($urandom_range(0, 1)));
  endtask

  function automatic byte_q_t chars_of(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t random_text(input int n);
    byte_q_t q;
    repeat (n) q.push_back(text_chars[$urandom_range(0, text_chars.len() - 1)]);
    return q;
  endfunction

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] lenb, input byte_q_t txt,
                            input logic [7:0] crc_err, input bit lose_flag, input int n_extra);
    logic [7:0] crc;
    logic [7:0] junk;
    repeat (((cfg_m.preamble_needed == 4'd0) ? 1 : int'(cfg_m.preamble_needed)) + n_extra) begin
      push_byte(cfg_m.preamble_byte);
    end
    if (lose_flag) begin
      junk = cfg_m.flag_byte;
      while (junk == cfg_m.flag_byte || junk == cfg_m.preamble_byte) junk = 8'($urandom);
      push_byte(junk);
    end
    push_byte(cfg_m.flag_byte);
    push_byte(addr);
    push_byte(lenb);
    if (int'(lenb) > payload_limit()) return;
    crc = crc8_next(crc8_next(cfg_m.crc_init, addr), lenb);
    foreach (txt[i]) begin
      push_byte(txt[i]);
      crc = crc8_next(crc, txt[i]);
    end
    push_byte(crc ^ crc_err);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_PREAMBLE_BYTE:   cfg_m.preamble_byte   = val;
      CFG_FLAG_BYTE:       cfg_m.flag_byte       = val;
      CFG_PREAMBLE_NEEDED: cfg_m.preamble_needed = val[3:0];
      CFG_MAX_PAYLOAD_LEN: cfg_m.max_payload_len = val[LEN_W-1:0];
      CFG_GROUP_ADDRESS:   cfg_m.group_address   = val;
      CFG_OWN_ADDR:        cfg_m.own_addr        = val;
      CFG_CRC_POLY:        cfg_m.crc_poly        = val;
      CFG_CRC_INIT:        cfg_m.crc_init        = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (line_bits.size() != 0 || s_axis_tvalid || pending_res.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // bit driver
  int unsigned send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_bit(s_axis_tdata[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (line_bits.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, line_bits.pop_front()};
          send_gap      <= calm ? 0 : rand_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver back-pressure
  int unsigned stall_left = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left    <= rand_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    frame_res_t want;
    frame_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ev   = event_e'(m_axis_tuser[2:0]);
      got.tv   = m_axis_tuser[3];
      got.addr = m_axis_tdata[7:0];
      got.len  = m_axis_tdata[14:8];
      got.txt  = m_axis_tdata[22:15];
      got.last = m_axis_tlast;
      if (pending_res.size() == 0) begin
        n_err++;
        $display("%0t: unexpected item: ev %0d addr %h len %0d txt %h tv %b last %b", $time,
                 got.ev, got.addr, got.len, got.txt, got.tv, got.last);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          n_err++;
          $display("%0t: mismatch: expected ev %0d addr %h len %0d txt %h tv %b last %b",
                   $time, want.ev, want.addr, want.len, want.txt, want.tv, want.last);
          $display("%0t:           actual   ev %0d addr %h len %0d txt %h tv %b last %b",
                   $time, got.ev, got.addr, got.len, got.txt, got.tv, got.last);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("bit_serial_frame_receiver_crc8_unit_tb failed");
    $finish;
  end

  initial begin
    byte_q_t      txt;
    logic [7:0]   pre;
    logic [7:0]   addr;
    logic [7:0]   lenb;
    logic [7:0]   err;
    frame_fault_e fault;
    int           lim;
    int           top;
    int           n;
    cfg_m = '{preamble_byte: 8'h55, flag_byte: 8'h7E, preamble_needed: 4'd2,
              max_payload_len: 7'd64, group_address: 8'hFF, own_addr: 8'h00,
              crc_poly: 8'h07, crc_init: 8'h00};
    rx_restart();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frame at reset settings
    send_frame(8'hFF, 8'd3, chars_of("A9/"), 8'h00, 1'b0, 0);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_PREAMBLE_BYTE, 8'h00);
          write_reg(CFG_FLAG_BYTE, 8'hFF);
          write_reg(CFG_PREAMBLE_NEEDED, 8'd0);
          write_reg(CFG_MAX_PAYLOAD_LEN, 8'd0);
          write_reg(CFG_GROUP_ADDRESS, 8'h00);
          write_reg(CFG_OWN_ADDR, 8'hFF);
          write_reg(CFG_CRC_POLY, 8'h00);
          write_reg(CFG_CRC_INIT, 8'hFF);
          write_reg(CFG_IDX_SPARE, 8'h5A);
        end
        1: begin
          // flag and preamble share one value
          write_reg(CFG_PREAMBLE_BYTE, 8'hA5);
          write_reg(CFG_FLAG_BYTE, 8'hA5);
          write_reg(CFG_PREAMBLE_NEEDED, 8'd1);
          write_reg(CFG_MAX_PAYLOAD_LEN, 8'd20);
          write_reg(CFG_GROUP_ADDRESS, 8'h3C);
          write_reg(CFG_OWN_ADDR, 8'h3C);
          write_reg(CFG_CRC_POLY, 8'h1D);
          write_reg(CFG_CRC_INIT, 8'h5A);
        end
        default: begin
          pre = 8'($urandom);
          write_reg(CFG_PREAMBLE_BYTE, pre);
          write_reg(CFG_FLAG_BYTE, ($urandom_range(0, 3) == 0) ? pre : 8'($urandom));
          write_reg(CFG_PREAMBLE_NEEDED, 8'($urandom_range(0, 3)));
          write_reg(CFG_MAX_PAYLOAD_LEN, 8'($urandom_range(0, MAX_PAYLOAD)));
          write_reg(CFG_GROUP_ADDRESS, 8'($urandom));
          write_reg(CFG_OWN_ADDR, 8'($urandom));
          write_reg(CFG_CRC_POLY, 8'($urandom));
          write_reg(CFG_CRC_INIT, 8'($urandom));
        end
      endcase

      lim   = payload_limit();
      top   = (lim > 3) ? 3 : lim;
      n     = $urandom_range(0, 10);
      fault = (n < 6) ? FLT_NONE : frame_fault_e'(n - 5);
      addr  = $urandom_range(0, 1) ? cfg_m.group_address : cfg_m.own_addr;
      if (fault == FLT_ADDR) begin
        while (addr == cfg_m.group_address || addr == cfg_m.own_addr) addr = 8'($urandom);
      end
      n = $urandom_range(0, top);
      if (fault == FLT_CHAR && n == 0 && lim > 0) n = 1;
      txt = random_text(n);
      if (fault == FLT_CHAR && n > 0) begin
        pre = 8'($urandom);
        while (char_ok(pre)) pre = 8'($urandom);
        txt[$urandom_range(0, n - 1)] = pre;
      end
      lenb = (fault == FLT_LEN) ? 8'($urandom_range(lim + 1, 255)) : 8'(n);
      err  = (fault == FLT_CRC) ? (8'h01 << $urandom_range(0, 7)) : 8'h00;
      if ($urandom_range(0, 3) == 0) line_noise();
      send_frame(addr, lenb, txt, err, fault == FLT_FLAG,
                 (cfg_m.flag_byte == cfg_m.preamble_byte) ? 0 : $urandom_range(0, 1));

      @(posedge clk_i);
      calm <= (ph == 2);
      if (ph == 1) hold_req <= 1'b1;
      wait_idle();
    end

    if (n_err == 0) begin
      $display("bit_serial_frame_receiver_crc8_unit_tb passed");
    end else begin
      $display("bit_serial_frame_receiver_crc8_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== bit_serial_frame_receiver_crc8_unit.f =====
rtl/bsfr_pkg.sv
rtl/bsfr_ram.sv
rtl/bsfr_rx.sv
rtl/bsfr_out.sv
rtl/bit_serial_frame_receiver_crc8_unit.sv
test/bit_serial_frame_receiver_crc8_unit_tb.sv
